FILE: rtl/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

	localparam int unsigned STAMP_W = 32;
	localparam int unsigned HALF_W  = 16;
	localparam int unsigned ADDR_W  = 5;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_CONN   = 3'd1;
	localparam logic [2:0] CMD_RECORD = 3'd2;
	localparam logic [2:0] CMD_PLAY   = 3'd3;
	localparam logic [2:0] CMD_SAVE   = 3'd4;

	localparam logic [2:0] REG_RECORD_HALF  = 3'd0;
	localparam logic [2:0] REG_PLAY_HALF    = 3'd1;
	localparam logic [2:0] REG_FLASH_HALF   = 3'd2;
	localparam logic [2:0] REG_FLASH_WINDOW = 3'd3;
	localparam logic [2:0] REG_ERROR_HOLD   = 3'd4;

	localparam logic [HALF_W-1:0] RECORD_HALF_RST  = 16'd200;
	localparam logic [HALF_W-1:0] PLAY_HALF_RST    = 16'd500;
	localparam logic [HALF_W-1:0] FLASH_HALF_RST   = 16'd100;
	localparam logic [HALF_W-1:0] FLASH_WINDOW_RST = 16'd600;
	localparam logic [HALF_W-1:0] ERROR_HOLD_RST   = 16'd1000;

	typedef enum logic [2:0] {
		PAT_IDLE = 3'd0,
		PAT_REC  = 3'd1,
		PAT_PLAY = 3'd2,
		PAT_OK   = 3'd3,
		PAT_ERR  = 3'd4
	} pattern_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [2:0]         command;
		logic               flag;
		logic [STAMP_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic       led_on;
		logic [2:0] pattern_now;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic qbit;
	} div_status_t;

endpackage

FILE: rtl/lps_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; reports the quotient LSB.
module lps_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lps_pkg::STAMP_W-1:0]    dividend,
	input  logic [lps_pkg::HALF_W-1:0]     divisor,
	output lps_pkg::div_status_t           status
);

	logic                         busy_q;
	logic                         done_q;
	logic                         qbit_q;
	logic [4:0]                   count_q;
	logic [lps_pkg::HALF_W-1:0]   rem_q;
	logic [lps_pkg::STAMP_W-1:0]  dvd_q;
	logic [lps_pkg::HALF_W-1:0]   dvs_q;

	logic [lps_pkg::HALF_W:0]     trial;
	logic [lps_pkg::HALF_W:0]     diff;
	logic                         fits;

	assign trial = {rem_q, dvd_q[lps_pkg::STAMP_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 5'd1;
				if (count_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvd_q  <= dividend;
			// a zero half period acts as one
			dvs_q  <= (divisor == '0) ? lps_pkg::HALF_W'(1) : divisor;
			qbit_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[lps_pkg::HALF_W-1:0] : trial[lps_pkg::HALF_W-1:0];
			dvd_q  <= {dvd_q[lps_pkg::STAMP_W-2:0], 1'b0};
			qbit_q <= fits;
		end
	end

	assign status = '{busy: busy_q, done: done_q, qbit: qbit_q};

endmodule

FILE: rtl/led_pattern_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload       Handshake
// in        input      in_item_t     in_valid / in_stall
// out       output     out_item_t    out_valid / out_stall
// cfg       input      APB, 32 bit   psel / penable / pwrite, pready tied high
//
// A blinking tick is accepted, runs 32 steps of the shared divider, takes the
// quotient bit, then loads the output register. Other ticks go straight to the
// output register; set and save commands load no result.
// Reset clears all control state and loads the default periods.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile, but its result waits behind it.
module led_pattern_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lps_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lps_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lps_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	lps_pkg::seq_state_t           state_q, state_d;
	lps_pkg::pattern_t             pattern_q, pattern_d;
	logic [lps_pkg::STAMP_W-1:0]   start_q, start_d;
	logic                          conn_q, conn_d;
	logic                          rec_q, rec_d;
	logic                          play_q, play_d;
	logic                          led_q, led_d;
	logic                          out_valid_q, out_valid_d;
	lps_pkg::out_item_t            out_data_q, out_data_d;

	logic [lps_pkg::HALF_W-1:0]    record_half_q, play_half_q, flash_half_q;
	logic [lps_pkg::HALF_W-1:0]    flash_window_q, error_hold_q;

	logic [lps_pkg::STAMP_W-1:0]   elapsed;
	logic                          div_start;
	logic [lps_pkg::HALF_W-1:0]    div_half;
	lps_pkg::div_status_t          div_st;
	logic                          cfg_write;
	logic [2:0]                    reg_idx;

	assign elapsed   = in_data.now_ms - start_q;
	assign cfg_write = psel && penable && pwrite;
	assign reg_idx   = paddr[lps_pkg::ADDR_W-1:2];
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_half_q  <= lps_pkg::RECORD_HALF_RST;
			play_half_q    <= lps_pkg::PLAY_HALF_RST;
			flash_half_q   <= lps_pkg::FLASH_HALF_RST;
			flash_window_q <= lps_pkg::FLASH_WINDOW_RST;
			error_hold_q   <= lps_pkg::ERROR_HOLD_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				lps_pkg::REG_RECORD_HALF:  record_half_q  <= pwdata[lps_pkg::HALF_W-1:0];
				lps_pkg::REG_PLAY_HALF:    play_half_q    <= pwdata[lps_pkg::HALF_W-1:0];
				lps_pkg::REG_FLASH_HALF:   flash_half_q   <= pwdata[lps_pkg::HALF_W-1:0];
				lps_pkg::REG_FLASH_WINDOW: flash_window_q <= pwdata[lps_pkg::HALF_W-1:0];
				lps_pkg::REG_ERROR_HOLD:   error_hold_q   <= pwdata[lps_pkg::HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lps_pkg::REG_RECORD_HALF:  prdata = {16'd0, record_half_q};
			lps_pkg::REG_PLAY_HALF:    prdata = {16'd0, play_half_q};
			lps_pkg::REG_FLASH_HALF:   prdata = {16'd0, flash_half_q};
			lps_pkg::REG_FLASH_WINDOW: prdata = {16'd0, flash_window_q};
			lps_pkg::REG_ERROR_HOLD:   prdata = {16'd0, error_hold_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lps_pkg::ST_IDLE;
			pattern_q   <= lps_pkg::PAT_IDLE;
			start_q     <= '0;
			conn_q      <= 1'b0;
			rec_q       <= 1'b0;
			play_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pattern_q   <= pattern_d;
			start_q     <= start_d;
			conn_q      <= conn_d;
			rec_q       <= rec_d;
			play_q      <= play_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		led_q      <= led_d;
		out_data_q <= out_data_d;
	end

	always_comb begin
		state_d     = state_q;
		pattern_d   = pattern_q;
		start_d     = start_q;
		conn_d      = conn_q;
		rec_d       = rec_q;
		play_d      = play_q;
		led_d       = led_q;
		out_valid_d = out_valid_q;
		out_data_d  = out_data_q;
		in_stall    = 1'b1;
		div_start   = 1'b0;
		div_half    = record_half_q;

		// drop the output transaction once taken
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			lps_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (in_data.command)
						lps_pkg::CMD_CONN: conn_d = in_data.flag;
						lps_pkg::CMD_RECORD: begin
							rec_d = in_data.flag;
							if (in_data.flag) begin
								pattern_d = lps_pkg::PAT_REC;
								start_d   = in_data.now_ms;
							end else if (!play_q) begin
								pattern_d = lps_pkg::PAT_IDLE;
							end
						end
						lps_pkg::CMD_PLAY: begin
							play_d = in_data.flag;
							if (in_data.flag) begin
								pattern_d = lps_pkg::PAT_PLAY;
								start_d   = in_data.now_ms;
							end else if (!rec_q) begin
								pattern_d = lps_pkg::PAT_IDLE;
							end
						end
						lps_pkg::CMD_SAVE: begin
							pattern_d = in_data.flag ? lps_pkg::PAT_OK : lps_pkg::PAT_ERR;
							start_d   = in_data.now_ms;
						end
						lps_pkg::CMD_TICK: begin
							state_d = lps_pkg::ST_DONE;
							led_d   = conn_q;
							case (pattern_q) inside
								lps_pkg::PAT_REC: begin
									div_start = 1'b1;
									div_half  = record_half_q;
									state_d   = lps_pkg::ST_DIV;
								end
								lps_pkg::PAT_PLAY: begin
									div_start = 1'b1;
									div_half  = play_half_q;
									state_d   = lps_pkg::ST_DIV;
								end
								lps_pkg::PAT_OK, lps_pkg::PAT_ERR: begin
									if (pattern_q == lps_pkg::PAT_OK &&
									    elapsed < {16'd0, flash_window_q}) begin
										div_start = 1'b1;
										div_half  = flash_half_q;
										state_d   = lps_pkg::ST_DIV;
									end else if (pattern_q == lps_pkg::PAT_ERR &&
									             elapsed < {16'd0, error_hold_q}) begin
										led_d = 1'b1;
									end else begin
										// window over: fall back to the base pattern
										if (rec_q) begin
											pattern_d = lps_pkg::PAT_REC;
											start_d   = in_data.now_ms;
										end else if (play_q) begin
											pattern_d = lps_pkg::PAT_PLAY;
											start_d   = in_data.now_ms;
										end else begin
											pattern_d = lps_pkg::PAT_IDLE;
										end
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
			lps_pkg::ST_DIV: begin
				if (div_st.done) begin
					// lit while the quotient is even
					led_d   = !div_st.qbit;
					state_d = lps_pkg::ST_DONE;
				end
			end
			lps_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_data_d  = '{led_on: led_q, pattern_now: pattern_q};
					state_d     = lps_pkg::ST_IDLE;
				end
			end
			default: state_d = lps_pkg::ST_IDLE;
		endcase
	end

	lps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed),
		.divisor  (div_half),
		.status   (div_st)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_div_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lps_pkg::ST_DIV) |-> (div_st.busy || div_st.done))
		else $error("divider idle while waiting on it");

	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == lps_pkg::ST_DIV))
		else $error("divider finished outside a division");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == lps_pkg::ST_DONE))
		else $error("result shown without a finished tick");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic [2:0] CMD_MAX = 3'd7;  // highest code the command field can carry
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned NUM_PHASES = 8;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	lps_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lps_pkg::out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [lps_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predicted sequencer state and register copy
	logic [lps_pkg::HALF_W-1:0] period_ms [0:4];
	lps_pkg::pattern_t cur_pattern;
	logic [lps_pkg::STAMP_W-1:0] pattern_start;
	logic link_up;
	logic rec_on;
	logic play_on;

	lps_pkg::in_item_t send_q[$];
	lps_pkg::out_item_t led_expect_q[$];
	lps_pkg::out_item_t want;
	bit in_fire;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned err_count;
	logic [lps_pkg::STAMP_W-1:0] wall_ms;
	int unsigned stride_ms;

	led_pattern_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("** led_pattern_sequencer: FAILED **");
		$finish;
	end

	function automatic logic blink_lit(input logic [lps_pkg::STAMP_W-1:0] elapsed,
		input logic [lps_pkg::HALF_W-1:0] half);
		logic [lps_pkg::STAMP_W-1:0] div;
		div = (half == '0) ? 32'd1 : {16'd0, half};
		return ((elapsed / div) & 32'd1) == 32'd0;
	endfunction

	// window over: resume the active pattern, else go idle
	function automatic logic resume_base(input logic [lps_pkg::STAMP_W-1:0] now);
		if (rec_on) begin
			cur_pattern = lps_pkg::PAT_REC;
			pattern_start = now;
		end else if (play_on) begin
			cur_pattern = lps_pkg::PAT_PLAY;
			pattern_start = now;
		end else begin
			cur_pattern = lps_pkg::PAT_IDLE;
		end
		return link_up;
	endfunction

	task automatic step_sequencer(input lps_pkg::in_item_t it);
		logic [lps_pkg::STAMP_W-1:0] elapsed;
		logic lit;
		lps_pkg::out_item_t res;
		case (it.command)
			lps_pkg::CMD_CONN: link_up = it.flag;
			lps_pkg::CMD_RECORD: begin
				rec_on = it.flag;
				if (it.flag) begin
					cur_pattern = lps_pkg::PAT_REC;
					pattern_start = it.now_ms;
				end else if (!play_on) begin
					cur_pattern = lps_pkg::PAT_IDLE;
				end
			end
			lps_pkg::CMD_PLAY: begin
				play_on = it.flag;
				if (it.flag) begin
					cur_pattern = lps_pkg::PAT_PLAY;
					pattern_start = it.now_ms;
				end else if (!rec_on) begin
					cur_pattern = lps_pkg::PAT_IDLE;
				end
			end
			lps_pkg::CMD_SAVE: begin
				cur_pattern = it.flag ? lps_pkg::PAT_OK : lps_pkg::PAT_ERR;
				pattern_start = it.now_ms;
			end
			lps_pkg::CMD_TICK: begin
				elapsed = it.now_ms - pattern_start;
				case (cur_pattern)
					lps_pkg::PAT_REC:
						lit = blink_lit(elapsed, period_ms[lps_pkg::REG_RECORD_HALF]);
					lps_pkg::PAT_PLAY:
						lit = blink_lit(elapsed, period_ms[lps_pkg::REG_PLAY_HALF]);
					lps_pkg::PAT_OK: begin
						if (elapsed < {16'd0, period_ms[lps_pkg::REG_FLASH_WINDOW]})
							lit = blink_lit(elapsed, period_ms[lps_pkg::REG_FLASH_HALF]);
						else
							lit = resume_base(it.now_ms);
					end
					lps_pkg::PAT_ERR: begin
						if (elapsed < {16'd0, period_ms[lps_pkg::REG_ERROR_HOLD]})
							lit = 1'b1;
						else
							lit = resume_base(it.now_ms);
					end
					default: lit = link_up;
				endcase
				res.led_on = lit;
				res.pattern_now = cur_pattern;
				led_expect_q.push_back(res);
			end
			default: ;  // unknown command: no effect
		endcase
	endtask

	// input driver: present the next transaction once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data <= send_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// monitor: predict on every accepted input, check every accepted result
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (led_expect_q.size() == 0) begin
				$error("result with no prediction: led_on %0b pattern_now %0d",
					out_data.led_on, out_data.pattern_now);
				err_count++;
			end else begin
				want = led_expect_q.pop_front();
				if (out_data.led_on !== want.led_on) begin
					$error("led_on: expected %0b, got %0b", want.led_on, out_data.led_on);
					err_count++;
				end
				if (out_data.pattern_now !== want.pattern_now) begin
					$error("pattern_now: expected %0d, got %0d",
						want.pattern_now, out_data.pattern_now);
					err_count++;
				end
			end
		end
		if (in_fire)
			step_sequencer(in_data);
	end

	task automatic apb_access(input logic [2:0] idx, input logic wr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_period(input logic [2:0] idx);
		logic [31:0] rdata;
		apb_access(idx, 1'b0, '0, rdata);
		if (rdata[lps_pkg::HALF_W-1:0] !== period_ms[idx]) begin
			$error("prdata reg %0d: expected %0d, got %0d", idx, period_ms[idx],
				rdata[lps_pkg::HALF_W-1:0]);
			err_count++;
		end
	endtask

	task automatic program_period(input logic [2:0] idx,
		input logic [lps_pkg::HALF_W-1:0] value);
		logic [31:0] rdata;
		// upper bits are junk; only the low half-word is stored
		apb_access(idx, 1'b1, {16'($urandom()), value}, rdata);
		period_ms[idx] = value;
		check_period(idx);
	endtask

	task automatic push_item(input logic [2:0] cmd, input logic flag,
		input logic [lps_pkg::STAMP_W-1:0] now);
		lps_pkg::in_item_t it;
		it.command = cmd;
		it.flag = flag;
		it.now_ms = now;
		send_q.push_back(it);
	endtask

	function automatic lps_pkg::in_item_t random_item();
		lps_pkg::in_item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		it.flag = 1'($urandom_range(1));
		if ($urandom_range(99) < 3)
			wall_ms = $urandom();
		else
			wall_ms += $urandom_range(stride_ms);
		it.now_ms = wall_ms;
		if (pick < 58) begin
			it.command = lps_pkg::CMD_TICK;
		end else if (pick < 66) begin
			it.command = lps_pkg::CMD_CONN;
		end else if (pick < 76) begin
			it.command = lps_pkg::CMD_RECORD;
		end else if (pick < 86) begin
			it.command = lps_pkg::CMD_PLAY;
		end else if (pick < 95) begin
			it.command = lps_pkg::CMD_SAVE;
		end else if (pick < 97) begin
			it.command = 3'($urandom_range(CMD_MAX, lps_pkg::CMD_SAVE + 1));
		end else begin
			// stray timestamp, unrelated to the running clock
			it.command = lps_pkg::CMD_TICK;
			it.now_ms = $urandom();
		end
		return it;
	endfunction

	// wait for every transaction to be taken and every result to come back
	task automatic drain_and_settle();
		while (send_q.size() != 0 || in_valid || led_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned n_items;
		int unsigned widest;
		logic [lps_pkg::HALF_W-1:0] v;

		period_ms[lps_pkg::REG_RECORD_HALF] = lps_pkg::RECORD_HALF_RST;
		period_ms[lps_pkg::REG_PLAY_HALF] = lps_pkg::PLAY_HALF_RST;
		period_ms[lps_pkg::REG_FLASH_HALF] = lps_pkg::FLASH_HALF_RST;
		period_ms[lps_pkg::REG_FLASH_WINDOW] = lps_pkg::FLASH_WINDOW_RST;
		period_ms[lps_pkg::REG_ERROR_HOLD] = lps_pkg::ERROR_HOLD_RST;
		cur_pattern = lps_pkg::PAT_IDLE;
		pattern_start = '0;
		link_up = 1'b0;
		rec_on = 1'b0;
		play_on = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		err_count = 0;
		wall_ms = '0;
		stride_ms = 1;

		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 70; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 70; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase

			widest = 0;
			for (int r = lps_pkg::REG_RECORD_HALF; r <= lps_pkg::REG_ERROR_HOLD; r++) begin
				if (ph == 0) begin
					check_period(3'(r));
				end else begin
					case (ph)
						2: v = 16'hFFFF;
						3: v = '0;  // zero acts as one / window already over
						4: v = 16'd1;
						5: v = 16'($urandom_range(64, 1));
						7: v = 16'($urandom_range(65535, 1));
						default: v = 16'($urandom_range(600, 1));
					endcase
					program_period(3'(r), v);
				end
				if ({16'd0, period_ms[r]} > widest)
					widest = {16'd0, period_ms[r]};
			end
			stride_ms = widest / 2 + 2;

			if (ph == 0) begin
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd0);
				push_item(lps_pkg::CMD_CONN, 1'b1, 32'd5);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd10);
				push_item(lps_pkg::CMD_RECORD, 1'b1, 32'd1000);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd1199);
				push_item(lps_pkg::CMD_TICK, 1'b1, 32'd1200);
				push_item(lps_pkg::CMD_PLAY, 1'b1, 32'd2000);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd2500);
				push_item(lps_pkg::CMD_RECORD, 1'b0, 32'd2600);
				push_item(lps_pkg::CMD_SAVE, 1'b1, 32'd3000);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd3100);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd3600);
				push_item(lps_pkg::CMD_SAVE, 1'b0, 32'd4000);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd4999);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'd5000);
				push_item(lps_pkg::CMD_PLAY, 1'b0, 32'd5100);
				push_item(CMD_MAX, 1'b1, 32'd5200);
				push_item(lps_pkg::CMD_RECORD, 1'b1, 32'hFFFF_FF00);
				push_item(lps_pkg::CMD_SAVE, 1'b1, 32'hFFFF_FFF0);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'h0000_0100);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'h0000_0300);
				push_item(lps_pkg::CMD_CONN, 1'b0, 32'h7FFF_FFFF);
				push_item(lps_pkg::CMD_TICK, 1'b1, 32'hFFFF_FFFF);
				push_item(lps_pkg::CMD_RECORD, 1'b0, 32'h8000_0000);
				push_item(lps_pkg::CMD_TICK, 1'b0, 32'h8000_0001);
				wall_ms = 32'd6000;
				n_items = 110;
			end else begin
				wall_ms = (ph == 4) ? 32'hFFFF_FF80 : $urandom();
				n_items = 120;
			end

			for (int i = 0; i < n_items; i++) begin
				// hold off the sender until the block has fully drained
				if (ph == 1 && i == n_items / 2)
					drain_and_settle();
				send_q.push_back(random_item());
			end
			drain_and_settle();
		end

		if (err_count == 0)
			$display("** led_pattern_sequencer: PASSED **");
		else
			$display("** led_pattern_sequencer: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/lps_pkg.sv
rtl/lps_div.sv
rtl/led_pattern_sequencer.sv
tb/testbench.sv
